// ===== rtl/core/crcdf_pkg.sv =====
// shared types, constants and crc function of the crc32 packet deframer
package crcdf_pkg;

  localparam int unsigned MaxPayload   = 64;
  localparam int unsigned PayIdxW      = 6;
  localparam int unsigned LenW         = 7;
  localparam int unsigned PosW         = 7;
  localparam int unsigned HdrBytes     = 8;
  localparam int unsigned TrailerBytes = 4;
  localparam int unsigned RamDepth     = 2 * 64;
  localparam int unsigned RamAddrW     = 7;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcOnes = 32'hFFFFFFFF;

  // configuration register indexes
  localparam logic CfgMagicFirst  = 1'b0;
  localparam logic CfgMagicSecond = 1'b1;

  // header byte positions within the frame
  localparam logic [2:0] PosVersion = 3'd2;
  localparam logic [2:0] PosCommand = 3'd3;
  localparam logic [2:0] PosSeqLo   = 3'd4;
  localparam logic [2:0] PosSeqHi   = 3'd5;
  localparam logic [2:0] PosLenLo   = 3'd6;

  typedef enum logic [1:0] {
    BackIdle,
    BackRead,
    BackLoad,
    BackShow
  } back_state_e;

  // one good frame waiting for its results
  typedef struct packed {
    logic [7:0]      version;
    logic [7:0]      command;
    logic [15:0]     sequence_no;
    logic [LenW-1:0] length;
    logic            bank;
  } frame_desc_t;

  // reflected crc-32 over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/crcdf_ram.sv =====
// generic single write, single read ram with registered read data
module crcdf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/crcdf_front.sv =====
// front end: sync hunt, header capture, running crc, payload writes
module crcdf_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  input  logic                           beat_i,
  input  logic [7:0]                     data_byte_i,
  output logic                           ram_we_o,
  output logic [crcdf_pkg::RamAddrW-1:0] ram_waddr_o,
  output logic [7:0]                     ram_wdata_o,
  output logic                           push_o,
  output crcdf_pkg::frame_desc_t         desc_o
);

  logic [7:0]                  magic_first_q, magic_first_d;
  logic [7:0]                  magic_second_q, magic_second_d;
  logic [crcdf_pkg::PosW-1:0]  pos_q, pos_d;
  logic [7:0]                  version_q, version_d;
  logic [7:0]                  command_q, command_d;
  logic [15:0]                 seq_q, seq_d;
  logic [15:0]                 len_q, len_d;
  logic [31:0]                 crc_q, crc_d;
  logic [31:0]                 rcrc_q, rcrc_d;
  logic                        bank_q, bank_d;
  logic [31:0]                 crc_next;
  logic [crcdf_pkg::PosW-1:0]  pay_end;
  logic [crcdf_pkg::PosW-1:0]  trl_last;
  logic [crcdf_pkg::PosW-1:0]  pay_off;
  logic [crcdf_pkg::PosW-1:0]  trl_off;
  logic [31:0]                 rcrc_full;
  logic [15:0]                 len_full;

  assign crc_next = crcdf_pkg::crc_byte(crc_q, data_byte_i);
  assign pay_end  = crcdf_pkg::PosW'(crcdf_pkg::HdrBytes) + len_q[crcdf_pkg::LenW-1:0];
  assign trl_last = pay_end + crcdf_pkg::PosW'(crcdf_pkg::TrailerBytes - 1);
  assign pay_off  = pos_q - crcdf_pkg::PosW'(crcdf_pkg::HdrBytes);
  assign trl_off  = pos_q - pay_end;
  assign len_full = {data_byte_i, len_q[7:0]};

  always_comb begin
    rcrc_full = rcrc_q;
    case (trl_off[1:0])
      2'd0:    rcrc_full[7:0]   = data_byte_i;
      2'd1:    rcrc_full[15:8]  = data_byte_i;
      2'd2:    rcrc_full[23:16] = data_byte_i;
      default: rcrc_full[31:24] = data_byte_i;
    endcase
  end

  always_comb begin
    magic_first_d  = magic_first_q;
    magic_second_d = magic_second_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        crcdf_pkg::CfgMagicFirst:  magic_first_d  = cfg_data_i;
        crcdf_pkg::CfgMagicSecond: magic_second_d = cfg_data_i;
        default:                   magic_first_d  = magic_first_q;
      endcase
    end
  end

  always_comb begin
    pos_d       = pos_q;
    version_d   = version_q;
    command_d   = command_q;
    seq_d       = seq_q;
    len_d       = len_q;
    crc_d       = crc_q;
    rcrc_d      = rcrc_q;
    bank_d      = bank_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = {bank_q, pay_off[crcdf_pkg::PayIdxW-1:0]};
    ram_wdata_o = data_byte_i;
    push_o      = 1'b0;
    if (beat_i) begin
      if (pos_q == '0) begin
        if (data_byte_i == magic_first_q) begin
          pos_d = crcdf_pkg::PosW'(1);
        end
      end else if (pos_q == crcdf_pkg::PosW'(1)) begin
        if (data_byte_i != magic_second_q) begin
          // a repeated first sync byte keeps one byte matched
          pos_d = (data_byte_i == magic_first_q) ? crcdf_pkg::PosW'(1) : '0;
        end else begin
          pos_d  = crcdf_pkg::PosW'(2);
          crc_d  = crcdf_pkg::CrcOnes;
          rcrc_d = '0;
        end
      end else if (pos_q < crcdf_pkg::PosW'(crcdf_pkg::HdrBytes)) begin
        crc_d = crc_next;
        pos_d = pos_q + crcdf_pkg::PosW'(1);
        case (pos_q[2:0])
          crcdf_pkg::PosVersion: version_d = data_byte_i;
          crcdf_pkg::PosCommand: command_d = data_byte_i;
          crcdf_pkg::PosSeqLo:   seq_d[7:0]  = data_byte_i;
          crcdf_pkg::PosSeqHi:   seq_d[15:8] = data_byte_i;
          crcdf_pkg::PosLenLo:   len_d[7:0]  = data_byte_i;
          default: begin
            len_d[15:8] = data_byte_i;
            // oversize length drops the frame
            if (len_full > 16'(crcdf_pkg::MaxPayload)) begin
              pos_d = '0;
            end
          end
        endcase
      end else if (pos_q < pay_end) begin
        crc_d    = crc_next;
        ram_we_o = 1'b1;
        pos_d    = pos_q + crcdf_pkg::PosW'(1);
      end else begin
        rcrc_d = rcrc_full;
        if (pos_q != trl_last) begin
          pos_d = pos_q + crcdf_pkg::PosW'(1);
        end else begin
          pos_d = '0;
          if ((crc_q ^ crcdf_pkg::CrcOnes) == rcrc_full) begin
            push_o = 1'b1;
            bank_d = ~bank_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_first_q  <= 8'hA5;
      magic_second_q <= 8'h5A;
      pos_q          <= '0;
      crc_q          <= crcdf_pkg::CrcOnes;
      bank_q         <= 1'b0;
    end else begin
      magic_first_q  <= magic_first_d;
      magic_second_q <= magic_second_d;
      pos_q          <= pos_d;
      crc_q          <= crc_d;
      bank_q         <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    version_q <= version_d;
    command_q <= command_d;
    seq_q     <= seq_d;
    len_q     <= len_d;
    rcrc_q    <= rcrc_d;
  end

  assign desc_o.version     = version_q;
  assign desc_o.command     = command_q;
  assign desc_o.sequence_no = seq_q;
  assign desc_o.length      = len_q[crcdf_pkg::LenW-1:0];
  assign desc_o.bank        = bank_q;

endmodule

// ===== rtl/core/crcdf_queue.sv =====
// two entry queue of good frame descriptors between front and back
module crcdf_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  crcdf_pkg::frame_desc_t desc_i,
  input  logic                   pop_i,
  output crcdf_pkg::frame_desc_t desc_o,
  output logic                   empty_o,
  output logic                   full_o
);

  crcdf_pkg::frame_desc_t entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wptr_d  = push_i ? ~wptr_q : wptr_q;
    rptr_d  = pop_i ? ~rptr_q : rptr_q;
    count_d = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= desc_i;
    end
  end

  assign desc_o  = entry_q[rptr_q];
  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);

endmodule

// ===== rtl/core/crcdf_back.sv =====
// back end: reads the payload bank of a good frame and emits its results
module crcdf_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  crcdf_pkg::frame_desc_t         desc_i,
  output logic                           pop_o,
  output logic                           ram_re_o,
  output logic [crcdf_pkg::RamAddrW-1:0] ram_raddr_o,
  input  logic [7:0]                     ram_rdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     version_o,
  output logic [7:0]                     command_o,
  output logic [15:0]                    sequence_res_o,
  output logic [crcdf_pkg::LenW-1:0]     data_len_o,
  output logic                           has_payload_o,
  output logic [crcdf_pkg::PayIdxW-1:0]  byte_index_o,
  output logic [7:0]                     payload_byte_o,
  output logic                           last_o
);

  crcdf_pkg::back_state_e state_q, state_d;
  logic [crcdf_pkg::PayIdxW-1:0] idx_q, idx_d;
  logic                          load;
  logic                          is_last;
  logic                          has_pay;
  logic [7:0]                    version_q;
  logic [7:0]                    command_q;
  logic [15:0]                   seq_q;
  logic [crcdf_pkg::LenW-1:0]    len_q;
  logic                          has_pay_q;
  logic [crcdf_pkg::PayIdxW-1:0] index_q;
  logic [7:0]                    byte_q;
  logic                          last_q;

  assign has_pay = (desc_i.length != '0);
  assign is_last = !has_pay ||
                   ({1'b0, idx_q} == (desc_i.length - crcdf_pkg::LenW'(1)));
  assign ram_raddr_o = {desc_i.bank, idx_q};

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    load        = 1'b0;
    pop_o       = 1'b0;
    ram_re_o    = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      crcdf_pkg::BackIdle: begin
        idx_d = '0;
        if (!empty_i) begin
          state_d = crcdf_pkg::BackRead;
        end
      end
      crcdf_pkg::BackRead: begin
        ram_re_o = 1'b1;
        state_d  = crcdf_pkg::BackLoad;
      end
      crcdf_pkg::BackLoad: begin
        load    = 1'b1;
        state_d = crcdf_pkg::BackShow;
      end
      crcdf_pkg::BackShow: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last_q) begin
            pop_o   = 1'b1;
            state_d = crcdf_pkg::BackIdle;
          end else begin
            idx_d   = idx_q + crcdf_pkg::PayIdxW'(1);
            state_d = crcdf_pkg::BackRead;
          end
        end
      end
      default: state_d = crcdf_pkg::BackIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crcdf_pkg::BackIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      version_q <= desc_i.version;
      command_q <= desc_i.command;
      seq_q     <= desc_i.sequence_no;
      len_q     <= desc_i.length;
      has_pay_q <= has_pay;
      index_q   <= has_pay ? idx_q : '0;
      byte_q    <= has_pay ? ram_rdata_i : 8'd0;
      last_q    <= is_last;
    end
  end

  assign version_o      = version_q;
  assign command_o      = command_q;
  assign sequence_res_o = seq_q;
  assign data_len_o     = len_q;
  assign has_payload_o  = has_pay_q;
  assign byte_index_o   = index_q;
  assign payload_byte_o = byte_q;
  assign last_o         = last_q;

endmodule

// ===== rtl/core/crc32_packet_deframer.sv =====
// top level of the crc32 checked packet deframer
// The deframer takes one received byte per input beat and accepts a byte in
// every cycle while fewer than two good frames wait for delivery. It hunts
// for the two sync bytes (config registers 0 and 1), collects the header,
// the payload of up to 64 bytes and a little-endian reflected crc-32, and
// drops frames with an oversize length or a crc mismatch without a trace.
// Payload bytes go into a two-bank payload ram, one bank per frame, so the
// front end can receive the next frame while the back end still delivers
// the last one. A good frame emits one output beat per payload byte, or a
// single beat with has_payload low for an empty payload. Each result passes
// in turn through a ram read, a register load and an output beat held
// until out_ready; the front end stalls only when two good frames are
// queued. The config port is always ready.
module crc32_packet_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // received bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  version_o,
  output logic [7:0]  command_o,
  output logic [15:0] sequence_res_o,
  output logic [6:0]  data_len_o,
  output logic        has_payload_o,
  output logic [5:0]  byte_index_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o
);

  // handshake qualifiers
  logic in_beat;
  logic cfg_beat;

  // payload ram ports
  logic                           ram_we;
  logic [crcdf_pkg::RamAddrW-1:0] ram_waddr;
  logic [7:0]                     ram_wdata;
  logic                           ram_re;
  logic [crcdf_pkg::RamAddrW-1:0] ram_raddr;
  logic [7:0]                     ram_rdata;

  // descriptor queue
  logic                   push;
  logic                   pop;
  logic                   q_empty;
  logic                   q_full;
  crcdf_pkg::frame_desc_t push_desc;
  crcdf_pkg::frame_desc_t head_desc;

  assign cfg_ready_o = 1'b1;
  assign cfg_beat    = cfg_valid_i & cfg_ready_o;

  // both payload banks busy: hold off new bytes
  assign in_ready_o = ~q_full;
  assign in_beat    = in_valid_i & in_ready_o;

  crcdf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_beat),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .beat_i      (in_beat),
    .data_byte_i (data_byte_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  // two banks of payload bytes, bank bit on top of the address
  crcdf_ram #(
    .Width (8),
    .Depth (crcdf_pkg::RamDepth)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  crcdf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .pop_i   (pop),
    .desc_o  (head_desc),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  crcdf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .desc_i         (head_desc),
    .pop_o          (pop),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .version_o      (version_o),
    .command_o      (command_o),
    .sequence_res_o (sequence_res_o),
    .data_len_o     (data_len_o),
    .has_payload_o  (has_payload_o),
    .byte_index_o   (byte_index_o),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o)
  );

endmodule
